@@ rtl/core/bmo5_pkg.sv @@
// Shared constants and types for the block median of five.
`default_nettype none

package bmo5_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int BLOCK_LEN        = 5;
    localparam int MID_POS          = 2;
    localparam int FILL_W           = 3;

    localparam logic [FILL_W-1:0] FILL_EMPTY = '0;
    localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(BLOCK_LEN - 1);

    // Control outcome of one insertion step
    typedef struct packed {
        logic              done;
        logic [FILL_W-1:0] fill;
    } t_ins_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/bmo5_stream_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
`default_nettype none

interface bmo5_in_if
    import bmo5_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface bmo5_out_if
    import bmo5_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    block_done;
    logic [SAMPLE_WIDTH-1:0] minimum;
    logic [SAMPLE_WIDTH-1:0] median;
    logic [SAMPLE_WIDTH-1:0] maximum;

    modport source (output valid, output block_done, output minimum, output median,
                    output maximum, input ready);
    modport sink   (input valid, input block_done, input minimum, input median,
                    input maximum, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bmo5_insert.sv @@
// Insertion step: places one sample into the sorted store, keeping it in ascending order.
`default_nettype none

module bmo5_insert
    import bmo5_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic [SAMPLE_WIDTH-1:0] i_store [BLOCK_LEN],
    input  wire logic [FILL_W-1:0]       i_fill,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                    i_restart,
    output logic      [SAMPLE_WIDTH-1:0] o_store [BLOCK_LEN],
    output t_ins_ctrl                    o_ctrl
);

    logic [FILL_W-1:0]    fill_eff;
    logic [BLOCK_LEN-1:0] le;

    // restart or an out-of-range count starts an empty block
    assign fill_eff = (i_restart || (i_fill > FILL_LAST)) ? FILL_EMPTY : i_fill;

    // entries in the filled prefix that are not greater than the new sample
    always_comb begin
        for (int j = 0; j < BLOCK_LEN; j++) begin
            le[j] = (FILL_W'(j) < fill_eff) && (i_store[j] <= i_sample);
        end
    end

    always_comb begin
        o_store[0] = le[0] ? i_store[0] : i_sample;
        for (int j = 1; j < BLOCK_LEN; j++) begin
            if (le[j]) begin
                o_store[j] = i_store[j];
            end else if (le[j-1]) begin
                o_store[j] = i_sample;
            end else if (FILL_W'(j) <= fill_eff) begin
                o_store[j] = i_store[j-1];
            end else begin
                o_store[j] = i_store[j];
            end
        end
    end

    always_comb begin
        o_ctrl.done = (fill_eff == FILL_LAST);
        o_ctrl.fill = o_ctrl.done ? FILL_EMPTY : fill_eff + FILL_W'(1);
    end

endmodule

`default_nettype wire

@@ rtl/core/block_median_of_five_top.sv @@
// Top level of the block median of five: input stage, sorted store, result stage.
// Data path: input register, then result register; a stalled result output holds
//   the sample in the input register.
// Throughput: one sample per cycle unless the output stalls; combinational insertion.
// Reset (i_rst_n low, synchronous): both stages empty, fill count zero,
//   store entries cleared to zero.
`default_nettype none

module block_median_of_five_top
    import bmo5_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bmo5_in_if.sink   i_in,
    bmo5_out_if.source o_out
);

    // Input stage register
    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                    r_in_restart;

    // Sorted store and fill count of the current block
    logic [SAMPLE_WIDTH-1:0] r_store [BLOCK_LEN];
    logic [FILL_W-1:0]       r_fill;

    // Result stage register
    logic                    r_out_valid;
    logic                    r_out_done;
    logic [SAMPLE_WIDTH-1:0] r_out_min;
    logic [SAMPLE_WIDTH-1:0] r_out_med;
    logic [SAMPLE_WIDTH-1:0] r_out_max;

    logic [SAMPLE_WIDTH-1:0] n_store [BLOCK_LEN];
    t_ins_ctrl               n_ctrl;

    logic res_free;   // result stage can take a new result this cycle
    logic advance;    // input stage moves into the store and result stage
    logic in_xfer;    // input transfer this cycle

    assign res_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && res_free;
    assign in_xfer  = i_in.valid && i_in.ready;

    // Input stage is ready when empty or when its content moves on this cycle, so a
    // waiting result blocks the next transfer only while the input stage is full.
    assign i_in.ready = !r_in_valid || res_free;

    bmo5_insert #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_insert (
        .i_store  (r_store),
        .i_fill   (r_fill),
        .i_sample (r_in_sample),
        .i_restart(r_in_restart),
        .o_store  (n_store),
        .o_ctrl   (n_ctrl)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= in_xfer;
        end
        if (in_xfer) begin
            r_in_sample  <= i_in.sample;
            r_in_restart <= i_in.restart;
        end
    end

    // Store and fill count update once per advancing sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_EMPTY;
            for (int j = 0; j < BLOCK_LEN; j++) begin
                r_store[j] <= '0;
            end
        end else if (advance) begin
            r_fill  <= n_ctrl.fill;
            r_store <= n_store;
        end
    end

    // Result stage: min, median and max read straight from the updated store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_out_done <= n_ctrl.done;
            r_out_min  <= n_store[0];
            r_out_med  <= n_store[MID_POS];
            r_out_max  <= n_store[BLOCK_LEN-1];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.block_done = r_out_done;
    assign o_out.minimum    = r_out_min;
    assign o_out.median     = r_out_med;
    assign o_out.maximum    = r_out_max;

endmodule

`default_nettype wire
